/* src/lgls_pkg.sv */
// shared constants, codes and types of the led grid layer store
package lgls_pkg;

    localparam int PAD_COUNT   = 100;
    localparam int PAD_W       = $clog2(PAD_COUNT);
    localparam int ACT_W       = 3;
    localparam int COLOR_W     = 6;
    localparam int FLASH_W     = 8;
    localparam int BITS_W      = 8;
    localparam int LINE_W      = 4;
    localparam int BRIGHT_W    = 3;
    localparam int PROD_W      = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd7;
    localparam logic [FLASH_W-1:0]  FLASH_OFF    = 8'hff;

    localparam logic [ACT_W-1:0] ACT_SET   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FLASH = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PULSE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SHOW8 = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SHOW6 = 3'd4;

    localparam logic KIND_PLOT   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } rgb_t;

    typedef struct packed {
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] g;
        logic [PROD_W-1:0] b;
    } prod_t;

    // one queued command, one output word each
    typedef struct packed {
        logic             kind;
        logic [PAD_W-1:0] pad;
        rgb_t             col;
        prod_t            prod;
        rgb_t             aux;
        logic             flash_rep;
        logic             last;
    } cmd_t;

endpackage

/* src/lgls_if.sv */
// channel interfaces: led actions in, plot commands and layer reports out
interface lgls_cmd_if;
    import lgls_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [PAD_W-1:0]    pad;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [BITS_W-1:0]   bits;
    logic                vertical;
    logic [LINE_W-1:0]   line;

    modport source (output valid, action, pad, red, green, blue, bits, vertical, line,
                    input ready);
    modport sink (input valid, action, pad, red, green, blue, bits, vertical, line,
                  output ready);
endinterface

interface lgls_res_if;
    import lgls_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [PAD_W-1:0]    pad_out;
    logic [COLOR_W-1:0]  red_out;
    logic [COLOR_W-1:0]  green_out;
    logic [COLOR_W-1:0]  blue_out;
    logic [FLASH_W-1:0]  flash_red;
    logic [FLASH_W-1:0]  flash_green;
    logic [FLASH_W-1:0]  flash_blue;
    logic [COLOR_W-1:0]  pulse_red;
    logic [COLOR_W-1:0]  pulse_green;
    logic [COLOR_W-1:0]  pulse_blue;
    logic                last;

    modport source (output valid, kind, pad_out, red_out, green_out, blue_out,
                    flash_red, flash_green, flash_blue, pulse_red, pulse_green,
                    pulse_blue, last, input ready);
    modport sink (input valid, kind, pad_out, red_out, green_out, blue_out,
                  flash_red, flash_green, flash_blue, pulse_red, pulse_green,
                  pulse_blue, last, output ready);
endinterface

/* src/lgls_ram.sv */
// generic single-port-write ram with registered read
module lgls_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/lgls_front.sv */
// front end: accepts actions and expands them into one queued command per word
module lgls_front (
    input  logic                           clk,
    input  logic                           rst_n,
    lgls_cmd_if.sink                       cmd,
    input  logic [lgls_pkg::BRIGHT_W-1:0]  brightness,
    input  logic                           q_full,
    output logic                           push,
    output lgls_pkg::cmd_t                 push_data
);
    import lgls_pkg::*;

    localparam int SPAD_W = 8;
    localparam int STEP_W = 3;
    localparam int K_W    = 14;
    localparam logic [SPAD_W-1:0] PAD_LIMIT = SPAD_W'(PAD_COUNT);
    localparam logic [SPAD_W-1:0] ROW_STEP  = 8'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET,
        S_FLASH,
        S_PULSE,
        S_SHOW8,
        S_SHOW6
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [PAD_W-1:0]    pad_reg;
    rgb_t                rgb_reg;
    logic [BITS_W-1:0]   bits_reg;
    logic                vert_reg;
    logic [LINE_W-1:0]   line_reg;

    logic                need_push;
    logic                final_step;
    logic                adv;
    logic [SPAD_W-1:0]   spad;
    logic [SPAD_W-1:0]   line10;
    logic [K_W-1:0]      k;
    rgb_t                col;
    cmd_t                entry;
    logic                pad_ok;
    rgb_t                in_rgb;

    // 63*(b+5)^2-144 for each brightness level
    function automatic logic [K_W-1:0] k_factor(input logic [BRIGHT_W-1:0] b);
        logic [K_W-1:0] v;
        case (b)
            3'd0:    v = 14'd1431;
            3'd1:    v = 14'd2124;
            3'd2:    v = 14'd2943;
            3'd3:    v = 14'd3888;
            3'd4:    v = 14'd4959;
            3'd5:    v = 14'd6156;
            3'd6:    v = 14'd7479;
            default: v = 14'd8928;
        endcase
        return v;
    endfunction

    // (c-1)*k, meaningless for c == 0, which scales to zero downstream
    function automatic logic [PROD_W-1:0] prod_level(input logic [COLOR_W-1:0] c,
                                                     input logic [K_W-1:0] kf);
        logic [COLOR_W-1:0] cm1;
        cm1 = c - COLOR_W'(1);
        return PROD_W'(cm1) * PROD_W'(kf);
    endfunction

    assign in_rgb    = '{r: cmd.red, g: cmd.green, b: cmd.blue};
    assign pad_ok    = SPAD_W'(cmd.pad) < PAD_LIMIT;
    assign cmd.ready = (state_reg == S_IDLE);
    assign k         = k_factor(brightness);
    assign line10    = SPAD_W'(line_reg) * ROW_STEP;

    always_comb
    begin
        case (cmd.action)
            ACT_SET:   state_next = pad_ok ? S_SET : S_IDLE;
            ACT_FLASH: state_next = pad_ok ? S_FLASH : S_IDLE;
            // pulse with black colour behaves exactly as set to black
            ACT_PULSE: state_next = !pad_ok ? S_IDLE :
                                    (in_rgb == '0) ? S_SET : S_PULSE;
            ACT_SHOW8: state_next = S_SHOW8;
            ACT_SHOW6: state_next = S_SHOW6;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        need_push  = 1'b0;
        final_step = 1'b1;
        spad       = SPAD_W'(pad_reg);
        col        = rgb_reg;
        entry.kind      = KIND_PLOT;
        entry.aux       = '0;
        entry.flash_rep = 1'b0;
        entry.last      = 1'b0;
        case (state_reg)
            S_SET:
            begin
                need_push  = 1'b1;
                final_step = (step_reg != '0);
                entry.kind = (step_reg != '0) ? KIND_REPORT : KIND_PLOT;
                entry.last = final_step;
            end
            S_FLASH:
            begin
                need_push       = 1'b1;
                entry.kind      = KIND_REPORT;
                entry.aux       = rgb_reg;
                entry.flash_rep = 1'b1;
                entry.last      = 1'b1;
            end
            S_PULSE:
            begin
                need_push  = 1'b1;
                col        = '0;
                entry.kind = KIND_REPORT;
                entry.aux  = rgb_reg;
                entry.last = 1'b1;
            end
            S_SHOW8, S_SHOW6:
            begin
                if (state_reg == S_SHOW8)
                begin
                    final_step = (step_reg == 3'd7);
                    spad = vert_reg ? (SPAD_W'(step_reg) + 8'd1) * ROW_STEP + SPAD_W'(line_reg)
                                    : 8'd8 - SPAD_W'(step_reg) + line10;
                end
                else
                begin
                    final_step = (step_reg == 3'd5);
                    spad = vert_reg ? (SPAD_W'(step_reg) + 8'd2) * ROW_STEP + SPAD_W'(line_reg)
                                    : 8'd7 - SPAD_W'(step_reg) + line10;
                end
                col       = bits_reg[step_reg] ? rgb_reg : '0;
                need_push = spad < PAD_LIMIT;
                // down a column pads grow, so the next one may fall off the grid
                entry.last = final_step || (vert_reg && (spad + ROW_STEP >= PAD_LIMIT));
            end
            default:
            begin
                need_push  = 1'b0;
                final_step = 1'b1;
            end
        endcase
        entry.pad    = spad[PAD_W-1:0];
        entry.col    = col;
        entry.prod.r = prod_level(col.r, k);
        entry.prod.g = prod_level(col.g, k);
        entry.prod.b = prod_level(col.b, k);
    end

    assign adv       = (state_reg != S_IDLE) && (!need_push || !q_full);
    assign push      = (state_reg != S_IDLE) && need_push && !q_full;
    assign push_data = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else if (state_reg == S_IDLE)
        begin
            if (cmd.valid)
            begin
                state_reg <= state_next;
                step_reg  <= '0;
            end
        end
        else if (adv)
        begin
            if (final_step)
            begin
                state_reg <= S_IDLE;
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            pad_reg  <= cmd.pad;
            rgb_reg  <= in_rgb;
            bits_reg <= cmd.bits;
            vert_reg <= cmd.vertical;
            line_reg <= cmd.line;
        end
    end

endmodule

/* src/lgls_queue.sv */
// short command queue between front and back end
module lgls_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lgls_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output lgls_pkg::cmd_t  head
);
    import lgls_pkg::*;

    cmd_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/lgls_back.sv */
// back end: scales plot colours, keeps the steady layer, builds output words
module lgls_back (
    input  logic            clk,
    input  logic            rst_n,
    input  lgls_pkg::cmd_t  head,
    input  logic            q_empty,
    output logic            pop,
    lgls_res_if.source      res
);
    import lgls_pkg::*;

    localparam int DIV_SHIFT   = 5;
    localparam int X_W         = PROD_W - DIV_SHIFT;
    localparam int RECIP_W     = 14;
    localparam int M_W         = X_W + RECIP_W;
    localparam int RECIP_SHIFT = 22;
    // x/279 == (x*15034) >> 22 for every x the products can reach
    localparam logic [RECIP_W-1:0] RECIP = 14'd15034;

    typedef struct packed {
        logic                kind;
        logic [PAD_W-1:0]    pad;
        rgb_t                main;
        logic [FLASH_W-1:0]  fr;
        logic [FLASH_W-1:0]  fg;
        logic [FLASH_W-1:0]  fb;
        rgb_t                pulse;
        logic                last;
    } word_t;

    logic [PAD_COUNT-1:0] steady_vld_reg;
    logic                 rd_vld_reg;
    logic                 s1_valid_reg;
    cmd_t                 s1_cmd_reg;
    rgb_t                 s1_scaled_reg;
    logic                 out_valid_reg;
    word_t                out_reg;

    logic                 s1_adv;
    logic                 ram_we;
    logic [3*COLOR_W-1:0] ram_rdata;
    rgb_t                 steady_rd;
    rgb_t                 scaled;
    word_t                word;

    // zero stays zero, else (c-1)*k/8928 + 1, with the /8928 as >>5 then /279
    function automatic logic [COLOR_W-1:0] scale(input logic [COLOR_W-1:0] c,
                                                 input logic [PROD_W-1:0] p);
        logic [X_W-1:0] x;
        logic [M_W-1:0] m;
        x = p[PROD_W-1:DIV_SHIFT];
        m = M_W'(x) * M_W'(RECIP);
        return (c == '0) ? '0 : m[RECIP_SHIFT +: COLOR_W] + COLOR_W'(1);
    endfunction

    assign s1_adv = s1_valid_reg && (!out_valid_reg || res.ready);
    assign pop    = !q_empty && (!s1_valid_reg || s1_adv);
    // a flash report leaves the steady layer as it is
    assign ram_we = pop && ((head.kind == KIND_PLOT) || !head.flash_rep);

    assign scaled.r = scale(head.col.r, head.prod.r);
    assign scaled.g = scale(head.col.g, head.prod.g);
    assign scaled.b = scale(head.col.b, head.prod.b);

    lgls_ram #(
        .WIDTH (3*COLOR_W),
        .DEPTH (PAD_COUNT)
    ) u_steady (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head.pad),
        .wdata (head.col),
        .re    (pop),
        .raddr (head.pad),
        .rdata (ram_rdata)
    );

    assign steady_rd = rd_vld_reg ? rgb_t'(ram_rdata) : '0;

    always_comb
    begin
        word.kind = s1_cmd_reg.kind;
        word.pad  = s1_cmd_reg.pad;
        word.last = s1_cmd_reg.last;
        if (s1_cmd_reg.kind == KIND_PLOT)
        begin
            word.main  = s1_scaled_reg;
            word.fr    = '0;
            word.fg    = '0;
            word.fb    = '0;
            word.pulse = '0;
        end
        else if (s1_cmd_reg.flash_rep)
        begin
            word.main  = steady_rd;
            word.fr    = FLASH_W'(s1_cmd_reg.aux.r);
            word.fg    = FLASH_W'(s1_cmd_reg.aux.g);
            word.fb    = FLASH_W'(s1_cmd_reg.aux.b);
            word.pulse = '0;
        end
        else
        begin
            word.main  = s1_cmd_reg.col;
            word.fr    = FLASH_OFF;
            word.fg    = FLASH_OFF;
            word.fb    = FLASH_OFF;
            word.pulse = s1_cmd_reg.aux;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steady_vld_reg <= '0;
            rd_vld_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                steady_vld_reg[head.pad] <= 1'b1;
            end
            if (pop)
            begin
                rd_vld_reg <= steady_vld_reg[head.pad];
            end
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg    <= head;
            s1_scaled_reg <= scaled;
        end
        if (s1_adv)
        begin
            out_reg <= word;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.kind        = out_reg.kind;
    assign res.pad_out     = out_reg.pad;
    assign res.red_out     = out_reg.main.r;
    assign res.green_out   = out_reg.main.g;
    assign res.blue_out    = out_reg.main.b;
    assign res.flash_red   = out_reg.fr;
    assign res.flash_green = out_reg.fg;
    assign res.flash_blue  = out_reg.fb;
    assign res.pulse_red   = out_reg.pulse.r;
    assign res.pulse_green = out_reg.pulse.g;
    assign res.pulse_blue  = out_reg.pulse.b;
    assign res.last        = out_reg.last;

endmodule

/* src/led_grid_layer_store.sv */
// top level of the led grid layer store
//
//  port       dir   what it moves
//  cmd        in    led action word (set, flash, pulse, show eight, show six)
//  res        out   plot command or layer report word, last marks end of action
//  cfg_we     in    brightness write strobe
//  cfg_wdata  in    brightness level
//
// the front takes an action while idle, then steps through the words it expands: set or black
// pulse give a plot and a report, flash or other pulse a report, show eight 8 and show six 6
// pads (off-grid pads stepped but not pushed); off-grid pads and unused codes give no word.
// a four-word queue, a ram read stage and an output register follow; queued words leave
// one per cycle while res is ready. reset clears the steady-layer valid flags at once.
// a stalled output fills the queue and then holds the front.
module led_grid_layer_store (
    input  logic                           clk,
    input  logic                           rst_n,
    lgls_cmd_if.sink                       cmd,
    lgls_res_if.source                     res,
    input  logic                           cfg_we,
    input  logic [lgls_pkg::BRIGHT_W-1:0]  cfg_wdata
);
    import lgls_pkg::*;

    logic [BRIGHT_W-1:0] brightness_reg;
    logic                push;
    cmd_t                push_data;
    logic                q_full;
    logic                q_empty;
    logic                pop;
    cmd_t                head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHT_RESET;
        end
        else if (cfg_we)
        begin
            brightness_reg <= cfg_wdata;
        end
    end

    lgls_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .brightness (brightness_reg),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    lgls_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    lgls_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .res     (res)
    );

endmodule

/* tb/tb_led_grid_layer_store.sv */
// testbench of the led grid layer store: directed and random led actions, words checked in order
`timescale 1ns / 1ps

module tb_led_grid_layer_store;
    import lgls_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int GAP_PERCENT = 26;
    localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
    localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
    localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PAD_W-1:0]  pad;
        rgb_t              col;
        logic [BITS_W-1:0] bits;
        logic              vertical;
        logic [LINE_W-1:0] line;
    } led_action_t;

    typedef struct packed {
        logic [FLASH_W-1:0] r;
        logic [FLASH_W-1:0] g;
        logic [FLASH_W-1:0] b;
    } flash_rgb_t;

    typedef struct packed {
        logic               kind;
        logic [PAD_W-1:0]   pad;
        rgb_t               col;
        flash_rgb_t         flash;
        rgb_t               pulse;
        logic               last;
    } led_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [BRIGHT_W-1:0] cfg_wdata;

    lgls_cmd_if cmd_ch ();
    lgls_res_if res_ch ();

    led_grid_layer_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the three layers and the brightness register
    rgb_t          steady_col [PAD_COUNT];
    flash_rgb_t    flash_col [PAD_COUNT];
    rgb_t          pulse_col [PAD_COUNT];
    logic [BRIGHT_W-1:0] bright_level;

    led_word_t words_due [$];
    int        mismatch_count;
    int        cycle_count;
    bit        sender_gaps;
    bit        sink_stalls;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycle_count,
                     words_due.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic log_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
    endtask

    function automatic logic [COLOR_W-1:0] scale_level(input logic [COLOR_W-1:0] c);
        int unsigned lvl;
        int unsigned num;
        lvl = bright_level;
        if (c == 0)
            return '0;
        num = (int'(c) - 1) * (63 * (lvl + 5) * (lvl + 5) - 144);
        return COLOR_W'(num / (62 * 144) + 1);
    endfunction

    // plot word for a set on one pad, with the layer update that goes with it
    function automatic led_word_t set_pad_word(input int p, input rgb_t c);
        led_word_t w;
        w = '0;
        w.kind = KIND_PLOT;
        w.pad = PAD_W'(p);
        w.col.r = scale_level(c.r);
        w.col.g = scale_level(c.g);
        w.col.b = scale_level(c.b);
        steady_col[p] = c;
        flash_col[p] = {FLASH_OFF, FLASH_OFF, FLASH_OFF};
        pulse_col[p] = '0;
        return w;
    endfunction

    function automatic void apply_action(input led_action_t a);
        led_word_t words [8];
        int n;
        int i;
        int p;
        int count;
        int across;
        int down;
        rgb_t c;
        n = 0;
        case (a.action)
            ACT_SET, ACT_FLASH, ACT_PULSE:
            begin
                if (a.pad < PAD_COUNT)
                begin
                    if (a.action == ACT_SET)
                    begin
                        words[n] = set_pad_word(a.pad, a.col);
                        n++;
                    end
                    else if (a.action == ACT_FLASH)
                    begin
                        flash_col[a.pad] = {2'b00, a.col.r, 2'b00, a.col.g, 2'b00, a.col.b};
                        pulse_col[a.pad] = '0;
                    end
                    else
                    begin
                        // pulse of black acts as a set to black
                        if (a.col == '0)
                        begin
                            words[n] = set_pad_word(a.pad, '0);
                            n++;
                        end
                        else
                            pulse_col[a.pad] = a.col;
                        steady_col[a.pad] = '0;
                        flash_col[a.pad] = {FLASH_OFF, FLASH_OFF, FLASH_OFF};
                    end
                    words[n] = '0;
                    words[n].kind = KIND_REPORT;
                    words[n].pad = a.pad;
                    words[n].col = steady_col[a.pad];
                    words[n].flash = flash_col[a.pad];
                    words[n].pulse = pulse_col[a.pad];
                    n++;
                end
            end
            ACT_SHOW8, ACT_SHOW6:
            begin
                count = (a.action == ACT_SHOW8) ? 8 : 6;
                across = (a.action == ACT_SHOW8) ? 8 : 7;
                down = (a.action == ACT_SHOW8) ? 1 : 2;
                for (i = 0; i < count; i++)
                begin
                    p = a.vertical ? (i + down) * 10 + int'(a.line)
                                   : across - i + int'(a.line) * 10;
                    c = a.bits[i] ? a.col : '0;
                    // off-grid pads are dropped, the rest of the line still plots
                    if (p < PAD_COUNT)
                    begin
                        words[n] = set_pad_word(p, c);
                        n++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (n > 0)
            words[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
            words_due.push_back(words[i]);
    endfunction

    function automatic led_action_t make_action(input logic [ACT_W-1:0] act, input int pad,
                                                input int r, input int g, input int b,
                                                input int bits, input bit vert,
                                                input int line);
        led_action_t a;
        a.action = act;
        a.pad = PAD_W'(pad);
        a.col.r = COLOR_W'(r);
        a.col.g = COLOR_W'(g);
        a.col.b = COLOR_W'(b);
        a.bits = BITS_W'(bits);
        a.vertical = vert;
        a.line = LINE_W'(line);
        return a;
    endfunction

    function automatic logic [COLOR_W-1:0] random_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return COLOR_W'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic led_action_t random_action();
        led_action_t a;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            a.action = ACT_SET;
        else if (pick < 47)
            a.action = ACT_FLASH;
        else if (pick < 64)
            a.action = ACT_PULSE;
        else if (pick < 79)
            a.action = ACT_SHOW8;
        else if (pick < 94)
            a.action = ACT_SHOW6;
        else
            a.action = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        pick = $urandom_range(0, 7);
        // a small pool of pads so layers get revisited
        if (pick == 0)
            a.pad = PAD_W'($urandom_range(PAD_COUNT, 127));
        else if (pick < 4)
            a.pad = PAD_W'($urandom_range(0, 7));
        else
            a.pad = PAD_W'($urandom_range(0, PAD_COUNT - 1));
        a.col.r = random_level();
        a.col.g = random_level();
        a.col.b = random_level();
        if (a.action == ACT_PULSE && $urandom_range(0, 3) == 0)
            a.col = '0;
        a.bits = BITS_W'($urandom_range(0, 255));
        a.vertical = 1'($urandom_range(0, 1));
        a.line = ($urandom_range(0, 5) == 0) ? LINE_W'($urandom_range(10, 15))
                                             : LINE_W'($urandom_range(0, 9));
        return a;
    endfunction

    task automatic send_action(input led_action_t a);
        @(negedge clk);
        while (sender_gaps && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.action = a.action;
        cmd_ch.pad = a.pad;
        cmd_ch.red = a.col.r;
        cmd_ch.green = a.col.g;
        cmd_ch.blue = a.col.b;
        cmd_ch.bits = a.bits;
        cmd_ch.vertical = a.vertical;
        cmd_ch.line = a.line;
        cmd_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        apply_action(a);
    endtask

    // stop sending, wait for every due word, then let dropped actions clear the pipe
    task automatic wait_drained();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_brightness(input logic [BRIGHT_W-1:0] lvl);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = lvl;
        @(negedge clk);
        cfg_we = 1'b0;
        bright_level = lvl;
    endtask

    always @(negedge clk)
        res_ch.ready = !(sink_stalls && $urandom_range(0, 99) < GAP_PERCENT);

    always @(posedge clk)
    begin
        led_word_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (words_due.size() == 0)
                log_mismatch("unexpected word, pad", res_ch.pad_out, -1);
            else
            begin
                want = words_due.pop_front();
                if (res_ch.kind !== want.kind)
                    log_mismatch("kind", res_ch.kind, want.kind);
                if (res_ch.pad_out !== want.pad)
                    log_mismatch("pad_out", res_ch.pad_out, want.pad);
                if (res_ch.red_out !== want.col.r)
                    log_mismatch("red_out", res_ch.red_out, want.col.r);
                if (res_ch.green_out !== want.col.g)
                    log_mismatch("green_out", res_ch.green_out, want.col.g);
                if (res_ch.blue_out !== want.col.b)
                    log_mismatch("blue_out", res_ch.blue_out, want.col.b);
                if (res_ch.flash_red !== want.flash.r)
                    log_mismatch("flash_red", res_ch.flash_red, want.flash.r);
                if (res_ch.flash_green !== want.flash.g)
                    log_mismatch("flash_green", res_ch.flash_green, want.flash.g);
                if (res_ch.flash_blue !== want.flash.b)
                    log_mismatch("flash_blue", res_ch.flash_blue, want.flash.b);
                if (res_ch.pulse_red !== want.pulse.r)
                    log_mismatch("pulse_red", res_ch.pulse_red, want.pulse.r);
                if (res_ch.pulse_green !== want.pulse.g)
                    log_mismatch("pulse_green", res_ch.pulse_green, want.pulse.g);
                if (res_ch.pulse_blue !== want.pulse.b)
                    log_mismatch("pulse_blue", res_ch.pulse_blue, want.pulse.b);
                if (res_ch.last !== want.last)
                    log_mismatch("last", res_ch.last, want.last);
            end
        end
    end

    task automatic test_directed_actions();
        send_action(make_action(ACT_SET, 0, 63, 63, 63, 0, 0, 0));
        send_action(make_action(ACT_SET, 99, 1, 0, 63, 0, 0, 0));
        send_action(make_action(ACT_SET, 127, 63, 63, 63, 0, 0, 0));
        send_action(make_action(ACT_SET, 100, 5, 5, 5, 0, 0, 0));
        // flash on a pad never written reports the reset steady colour
        send_action(make_action(ACT_FLASH, 5, 63, 0, 42, 0, 0, 0));
        send_action(make_action(ACT_FLASH, 0, 0, 0, 0, 0, 0, 0));
        send_action(make_action(ACT_PULSE, 5, 21, 63, 1, 0, 0, 0));
        send_action(make_action(ACT_PULSE, 5, 0, 0, 0, 0, 0, 0));
        send_action(make_action(ACT_PULSE, 120, 3, 3, 3, 0, 0, 0));
        send_action(make_action(ACT_UNUSED_LO, 1, 9, 9, 9, 255, 1, 1));
        send_action(make_action(ACT_UNUSED_MID, 2, 9, 9, 9, 255, 0, 2));
        send_action(make_action(ACT_UNUSED_HI, 3, 9, 9, 9, 255, 1, 3));
        send_action(make_action(ACT_SHOW8, 127, 63, 63, 63, 8'hA5, 0, 0));
        send_action(make_action(ACT_SHOW8, 0, 33, 12, 63, 8'hFF, 1, 9));
        send_action(make_action(ACT_SHOW8, 0, 63, 63, 63, 8'h00, 0, 9));
        send_action(make_action(ACT_SHOW6, 0, 17, 40, 2, 8'h5A, 0, 4));
        send_action(make_action(ACT_SHOW6, 0, 63, 1, 63, 8'hC3, 1, 0));
        // horizontal line past the grid drops every plot
        send_action(make_action(ACT_SHOW8, 0, 63, 63, 63, 8'hFF, 0, 15));
        send_action(make_action(ACT_SHOW6, 0, 63, 63, 63, 8'hFF, 0, 10));
        send_action(make_action(ACT_SHOW6, 0, 7, 8, 9, 8'hFF, 1, 15));
        send_action(make_action(ACT_SHOW8, 0, 7, 8, 9, 8'h81, 1, 12));
        send_action(make_action(ACT_SET, 88, 0, 0, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_brightness_levels();
        int lvl;
        for (lvl = 0; lvl < 8; lvl++)
        begin
            write_brightness(BRIGHT_W'(lvl));
            send_action(make_action(ACT_SET, 10 + lvl, 63, 1, 0, 0, 0, 0));
            send_action(make_action(ACT_SET, 20 + lvl, random_level(), random_level(),
                                    random_level(), 0, 0, 0));
            send_action(make_action(ACT_SHOW6, 0, 2, 32, 62, 8'h3F, 0, lvl));
            wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        int i;
        for (phase = 0; phase < 4; phase++)
        begin
            write_brightness(BRIGHT_W'($urandom_range(0, 7)));
            for (i = 0; i < 40; i++)
                send_action(random_action());
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        int i;
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        write_brightness(3'd7);
        for (i = 0; i < 40; i++)
            send_action(random_action());
        wait_drained();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic test_pause_for_drain();
        int i;
        write_brightness(3'd0);
        for (i = 0; i < 15; i++)
            send_action(random_action());
        // hold the sender until every due word is out, then resume
        wait_drained();
        for (i = 0; i < 15; i++)
            send_action(random_action());
        wait_drained();
    endtask

    initial
    begin
        int p;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.action = ACT_SET;
        cmd_ch.pad = '0;
        cmd_ch.red = '0;
        cmd_ch.green = '0;
        cmd_ch.blue = '0;
        cmd_ch.bits = '0;
        cmd_ch.vertical = 1'b0;
        cmd_ch.line = '0;
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        bright_level = BRIGHT_RESET;
        for (p = 0; p < PAD_COUNT; p++)
        begin
            steady_col[p] = '0;
            flash_col[p] = '0;
            pulse_col[p] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_actions();
        test_brightness_levels();
        test_random_traffic();
        test_back_to_back();
        test_pause_for_drain();

        if (words_due.size() != 0)
            log_mismatch("words never seen", 0, words_due.size());
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
